// File: design/aes_cbc_cipher_engine_macros.svh
// Assertion macros shared by the AES CBC engine RTL.
`ifndef AES_CBC_CIPHER_ENGINE_MACROS_SVH
`define AES_CBC_CIPHER_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled in reset.
`define AC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled in reset.
`define AC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/aes_cbc_pkg.sv
// Package with the types, constants and S-box tables of the AES CBC engine.
`default_nettype none

package aes_cbc_pkg;

    typedef logic [255:0][7:0] t_sbox_tab;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEXP,
        S_INIT,
        S_ROUND,
        S_FIN
    } t_state;

    typedef struct packed {
        logic       start;
        logic       step;
        logic [3:0] rd_idx;
    } t_kx_ctl;

    localparam int unsigned NUM_RK = 15;

    localparam logic [1:0] KSEL_128 = 2'd0;
    localparam logic [1:0] KSEL_192 = 2'd1;

    localparam logic DIR_ENC = 1'b0;
    localparam logic DIR_DEC = 1'b1;

    localparam logic [2:0] REG_KSEL  = 3'd0;
    localparam logic [2:0] REG_DIR   = 3'd1;
    localparam logic [2:0] REG_KEY0  = 3'd2;
    localparam logic [2:0] REG_KEY1  = 3'd3;
    localparam logic [2:0] REG_KEY2  = 3'd4;
    localparam logic [2:0] REG_KEY3  = 3'd5;
    localparam logic [2:0] REG_IV_HI = 3'd6;
    localparam logic [2:0] REG_IV_LO = 3'd7;

    localparam logic [7:0] PAD_BYTE = 8'h08;

    function automatic logic [7:0] f_rotl8(input logic [7:0] x, input int n);
        return 8'((x << n) | (x >> (8 - n)));
    endfunction

    function automatic logic [7:0] f_xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_sbox_tab f_build_sbox();
        t_sbox_tab  t;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] x;
        t = '0;
        p = 8'h01;
        q = 8'h01;
        for (int k = 0; k < 255; k++) begin
            p = p ^ 8'(p << 1) ^ (p[7] ? 8'h1b : 8'h00);
            q = q ^ 8'(q << 1);
            q = q ^ 8'(q << 2);
            q = q ^ 8'(q << 4);
            if (q[7]) begin
                q = q ^ 8'h09;
            end
            x = q ^ f_rotl8(q, 1) ^ f_rotl8(q, 2) ^ f_rotl8(q, 3) ^ f_rotl8(q, 4);
            t[p] = x ^ 8'h63;
        end
        t[0] = 8'h63;
        return t;
    endfunction

    function automatic t_sbox_tab f_build_inv(input t_sbox_tab s);
        t_sbox_tab t;
        t = '0;
        for (int i = 0; i < 256; i++) begin
            t[s[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam t_sbox_tab SBOX     = f_build_sbox();
    localparam t_sbox_tab INV_SBOX = f_build_inv(SBOX);

    function automatic logic [3:0] f_nk(input logic [1:0] ksel);
        case (ksel)
            KSEL_128: return 4'd4;
            KSEL_192: return 4'd6;
            default:  return 4'd8;
        endcase
    endfunction

    function automatic logic [3:0] f_nr(input logic [1:0] ksel);
        case (ksel)
            KSEL_128: return 4'd10;
            KSEL_192: return 4'd12;
            default:  return 4'd14;
        endcase
    endfunction

endpackage

`default_nettype wire

// File: design/aes_cbc_round.sv
// Shared AES round unit for both cipher directions.
`default_nettype none

module aes_cbc_round
    import aes_cbc_pkg::*;
(
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    input  logic         i_dir,
    input  logic         i_last,
    output logic [127:0] o_state
);

    function automatic logic [31:0] f_mix(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24];
        a1 = w[23:16];
        a2 = w[15:8];
        a3 = w[7:0];
        return {f_xt(a0) ^ f_xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ f_xt(a1) ^ f_xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ f_xt(a2) ^ f_xt(a3) ^ a3,
                f_xt(a0) ^ a0 ^ a1 ^ a2 ^ f_xt(a3)};
    endfunction

    function automatic logic [31:0] f_inv_mix(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2, x4, x8;
        for (int k = 0; k < 4; k++) begin
            a[k]   = w[31-8*k -: 8];
            x2     = f_xt(a[k]);
            x4     = f_xt(x2);
            x8     = f_xt(x4);
            m9[k]  = x8 ^ a[k];
            m11[k] = x8 ^ x2 ^ a[k];
            m13[k] = x8 ^ x4 ^ a[k];
            m14[k] = x8 ^ x4 ^ x2;
        end
        return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
                m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
                m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
    endfunction

    always_comb begin
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [127:0] tv;
        logic [127:0] uv;
        for (int b = 0; b < 16; b++) begin
            s[b] = i_state[127-8*b -: 8];
        end
        if (i_dir == DIR_ENC) begin
            for (int c = 0; c < 4; c++) begin
                for (int i = 0; i < 4; i++) begin
                    t[i+4*c] = SBOX[s[i+4*((c+i)&3)]];
                end
            end
        end else begin
            for (int c = 0; c < 4; c++) begin
                for (int i = 0; i < 4; i++) begin
                    t[i+4*((c+i)&3)] = INV_SBOX[s[i+4*c]];
                end
            end
        end
        for (int b = 0; b < 16; b++) begin
            tv[127-8*b -: 8] = t[b];
        end
        if (i_dir == DIR_ENC) begin
            uv = tv;
            if (!i_last) begin
                for (int c = 0; c < 4; c++) begin
                    uv[127-32*c -: 32] = f_mix(tv[127-32*c -: 32]);
                end
            end
            uv = uv ^ i_key;
        end else begin
            tv = tv ^ i_key;
            uv = tv;
            if (!i_last) begin
                for (int c = 0; c < 4; c++) begin
                    uv[127-32*c -: 32] = f_inv_mix(tv[127-32*c -: 32]);
                end
            end
        end
        o_state = uv;
    end

endmodule

`default_nettype wire

// File: design/aes_cbc_kexp.sv
// AES key schedule, one word per cycle while stepped, with the round key store.
`default_nettype none

module aes_cbc_kexp
    import aes_cbc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_kx_ctl        i_ctl,
    input  logic [255:0]   i_key,
    input  logic [1:0]     i_key_size_sel,
    output logic [127:0]   o_round_key,
    output logic           o_done
);

    logic [0:3][31:0] r_rk [NUM_RK];
    logic [31:0]      r_win [8];
    logic [31:0]      n_win [8];
    logic [5:0]       r_widx;
    logic [2:0]       r_kmod;
    logic [7:0]       r_rcon;
    logic [3:0]       w_nk;
    logic [5:0]       w_last_idx;
    logic [31:0]      w_temp;
    logic [31:0]      w_new;
    logic [31:0]      w_kw [8];

    assign w_nk        = f_nk(i_key_size_sel);
    assign w_last_idx  = {f_nr(i_key_size_sel), 2'b11};
    assign o_done      = (r_widx == w_last_idx);
    assign o_round_key = r_rk[i_ctl.rd_idx];

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            w_kw[j] = i_key[255-32*j -: 32];
        end
        w_temp = r_win[0];
        if (r_kmod == 3'd0) begin
            w_temp = {SBOX[r_win[0][23:16]] ^ r_rcon, SBOX[r_win[0][15:8]],
                      SBOX[r_win[0][7:0]], SBOX[r_win[0][31:24]]};
        end else if (w_nk == 4'd8 && r_kmod == 3'd4) begin
            w_temp = {SBOX[r_win[0][31:24]], SBOX[r_win[0][23:16]],
                      SBOX[r_win[0][15:8]], SBOX[r_win[0][7:0]]};
        end
        w_new = r_win[3'(w_nk - 4'd1)] ^ w_temp;
        n_win[0] = w_new;
        for (int k = 1; k < 8; k++) begin
            n_win[k] = r_win[k-1];
        end
        if (i_ctl.start) begin
            for (int k = 0; k < 8; k++) begin
                n_win[k] = (k < int'(w_nk)) ? w_kw[3'(int'(w_nk) - 1 - k)] : 32'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx <= '0;
            r_kmod <= '0;
        end else if (i_ctl.start) begin
            r_widx <= 6'(w_nk);
            r_kmod <= '0;
        end else if (i_ctl.step) begin
            r_widx <= r_widx + 6'd1;
            r_kmod <= (r_kmod == 3'(w_nk - 4'd1)) ? 3'd0 : r_kmod + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rk[0] <= i_key[255:128];
            r_rk[1] <= i_key[127:0];
            r_rcon  <= 8'h01;
        end else if (i_ctl.step) begin
            r_rk[r_widx[5:2]][r_widx[1:0]] <= w_new;
            if (r_kmod == 3'd0) begin
                r_rcon <= f_xt(r_rcon);
            end
        end
        if (i_ctl.start || i_ctl.step) begin
            r_win <= n_win;
        end
    end

endmodule

`default_nettype wire

// File: design/aes_cbc_cipher_engine.sv
// Top level of the AES CBC engine: register port, sequencer and result register.
//
// Channel   Dir  Handshake                   Beat payload
// input     in   i_in_valid / o_in_stall     i_block_high, i_block_low, i_byte_count
// output    out  o_out_valid / i_out_stall   o_result_high, o_result_low, o_status
// config    in   APB psel/penable/pready     paddr, pwdata, prdata (64-bit registers)
//
// From acceptance to the next acceptance a block passes through accept, the key
// schedule at one word per cycle, the initial key add, the rounds through the
// shared round unit and finish, which waits while the output is stalled.
// A beat without a loaded IV goes straight to finish with zero data and error status.
// Reset is synchronous and clears configuration, chain and handshake state.
// A stalled result holds in the output register; the next beat is accepted meanwhile.
`default_nettype none

module aes_cbc_cipher_engine
    import aes_cbc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [63:0]  i_block_high,
    input  logic [63:0]  i_block_low,
    input  logic [4:0]   i_byte_count,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic [63:0]  o_result_high,
    output logic [63:0]  o_result_low,
    output logic         o_status,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

`include "aes_cbc_cipher_engine_macros.svh"

    logic [1:0]   r_ksel;
    logic         r_dir;
    logic [63:0]  r_key [4];
    logic [63:0]  r_iv_hi;
    logic [63:0]  r_iv_lo;
    logic [127:0] r_chain;
    logic         r_iv_valid;
    t_state       r_state;
    t_state       n_state;
    logic [127:0] r_data;
    logic [127:0] r_blk;
    logic [3:0]   r_rnd;
    logic         r_nodata;
    logic         r_out_valid;
    logic [63:0]  r_out_hi;
    logic [63:0]  r_out_lo;
    logic         r_out_status;

    logic         w_cfg_wr;
    logic [2:0]   w_cfg_idx;
    logic         w_accept;
    logic         w_out_free;
    logic         w_fin_fire;
    logic         w_last;
    logic [3:0]   w_nr;
    logic [4:0]   w_cnt;
    logic [127:0] w_padded;
    logic [127:0] w_rk;
    logic [127:0] w_rnd_out;
    logic [127:0] w_result;
    logic         w_kx_done;
    t_kx_ctl      w_kx_ctl;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = paddr[5:3];
    assign w_nr      = f_nr(r_ksel);
    assign w_last    = (r_dir == DIR_DEC) ? (r_rnd == 4'd0) : (r_rnd == w_nr);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        case (w_cfg_idx)
            REG_KSEL:  prdata = {62'd0, r_ksel};
            REG_DIR:   prdata = {63'd0, r_dir};
            REG_KEY0:  prdata = r_key[0];
            REG_KEY1:  prdata = r_key[1];
            REG_KEY2:  prdata = r_key[2];
            REG_KEY3:  prdata = r_key[3];
            REG_IV_HI: prdata = r_iv_hi;
            REG_IV_LO: prdata = r_iv_lo;
            default:   prdata = 64'd0;
        endcase
    end

    always_comb begin
        logic [127:0] raw;
        raw   = {i_block_high, i_block_low};
        w_cnt = (i_byte_count == 5'd0 || i_byte_count > 5'd16) ? 5'd16 : i_byte_count;
        for (int b = 0; b < 16; b++) begin
            if (5'(b) < w_cnt) begin
                w_padded[127-8*b -: 8] = raw[127-8*b -: 8];
            end else if (5'(b) == w_cnt) begin
                w_padded[127-8*b -: 8] = PAD_BYTE;
            end else begin
                w_padded[127-8*b -: 8] = 8'd0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = r_iv_valid ? S_KEXP : S_FIN;
                end
            end
            S_KEXP: begin
                if (w_kx_done) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (w_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall      = 1'b1;
        w_fin_fire      = 1'b0;
        w_kx_ctl.start  = 1'b0;
        w_kx_ctl.step   = 1'b0;
        w_kx_ctl.rd_idx = r_rnd;
        case (r_state)
            S_IDLE: begin
                o_in_stall     = 1'b0;
                w_kx_ctl.start = i_in_valid & r_iv_valid;
            end
            S_KEXP: begin
                w_kx_ctl.step = 1'b1;
            end
            S_FIN: begin
                w_fin_fire = w_out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign w_accept = i_in_valid & !o_in_stall;

    aes_cbc_kexp u_kexp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_kx_ctl),
        .i_key          ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_key_size_sel (r_ksel),
        .o_round_key    (w_rk),
        .o_done         (w_kx_done)
    );

    aes_cbc_round u_round (
        .i_state (r_data),
        .i_key   (w_rk),
        .i_dir   (r_dir),
        .i_last  (w_last),
        .o_state (w_rnd_out)
    );

    assign w_result = r_nodata ? 128'd0 :
                      (r_dir == DIR_DEC) ? (r_data ^ r_chain) : r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ksel      <= '0;
            r_dir       <= DIR_ENC;
            r_key       <= '{default: '0};
            r_iv_hi     <= '0;
            r_iv_lo     <= '0;
            r_chain     <= '0;
            r_iv_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_fin_fire && !r_nodata) begin
                r_chain <= (r_dir == DIR_DEC) ? r_blk : r_data;
            end
            if (w_cfg_wr) begin
                case (w_cfg_idx)
                    REG_KSEL: r_ksel <= pwdata[1:0];
                    REG_DIR:  r_dir  <= pwdata[0];
                    REG_KEY0: r_key[0] <= pwdata;
                    REG_KEY1: r_key[1] <= pwdata;
                    REG_KEY2: r_key[2] <= pwdata;
                    REG_KEY3: r_key[3] <= pwdata;
                    REG_IV_HI: begin
                        r_iv_hi    <= pwdata;
                        r_chain    <= {pwdata, r_iv_lo};
                        r_iv_valid <= 1'b1;
                    end
                    REG_IV_LO: begin
                        r_iv_lo    <= pwdata;
                        r_chain    <= {r_iv_hi, pwdata};
                        r_iv_valid <= 1'b1;
                    end
                    default: begin
                        r_iv_valid <= r_iv_valid;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_blk    <= w_padded;
            r_data   <= (r_dir == DIR_DEC) ? w_padded : (w_padded ^ r_chain);
            r_nodata <= !r_iv_valid;
            r_rnd    <= (r_dir == DIR_DEC) ? w_nr : 4'd0;
        end else if (r_state == S_INIT || r_state == S_ROUND) begin
            r_data <= (r_state == S_INIT) ? (r_data ^ w_rk) : w_rnd_out;
            r_rnd  <= (r_dir == DIR_DEC) ? (r_rnd - 4'd1) : (r_rnd + 4'd1);
        end
        if (w_fin_fire) begin
            r_out_hi     <= w_result[127:64];
            r_out_lo     <= w_result[63:0];
            r_out_status <= r_nodata;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_high = r_out_hi;
    assign o_result_low  = r_out_lo;
    assign o_status      = r_out_status;

    `AC_ASSERT_IMP(a_err_zero, o_out_valid && o_status,
                   o_result_high == 64'd0 && o_result_low == 64'd0, "error result carries data")
    `AC_ASSERT_IMP(a_rnd_range, r_state == S_ROUND, r_rnd <= w_nr,
                   "round index beyond round count")
    `AC_ASSERT_NXT(a_kexp_next, r_state == S_KEXP, r_state == S_KEXP || r_state == S_INIT,
                   "key schedule left early")
    `AC_ASSERT_IMP(a_iv_set, $rose(r_iv_valid), $past(w_cfg_wr),
                   "IV valid set without a write")

endmodule

`default_nettype wire
